// ===== hw/rtl/cdgr_pkg.sv =====
// Shared types, constants and packet helpers for the CD+G packet renderer.
package cdgr_pkg;

  localparam int SCREEN_WIDTH  = 300;
  localparam int SCREEN_HEIGHT = 216;
  localparam int TILE_W        = 6;
  localparam int TILE_H        = 12;
  localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = $clog2(STORE_SIZE);

  // Tile origin spans: column field is 6 bits, row field is 5 bits.
  localparam int TILE_X_SPAN = 64 * TILE_W;
  localparam int TILE_Y_SPAN = 32 * TILE_H;
  localparam int TILE_X_W    = $clog2(TILE_X_SPAN);
  localparam int TILE_Y_W    = $clog2(TILE_Y_SPAN);
  localparam int TADDR_W     = $clog2(TILE_Y_SPAN * SCREEN_WIDTH + TILE_X_SPAN);
  localparam int COL_W       = $clog2(TILE_W);
  localparam int ROW_W       = $clog2(TILE_H);

  // Pixel read address before the range check.
  localparam int RD_W = $clog2(256 * SCREEN_WIDTH + 512);

  localparam logic [1:0] KIND_PACKET = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_PAL    = 2'd2;

  localparam logic [5:0] CMD_GFX      = 6'h09;
  localparam logic [5:0] INS_PRESET   = 6'd1;
  localparam logic [5:0] INS_TILE     = 6'd6;
  localparam logic [5:0] INS_TILE_XOR = 6'd38;
  localparam logic [5:0] INS_PAL_LO   = 6'd30;
  localparam logic [5:0] INS_PAL_HI   = 6'd31;

  localparam logic [2:0] ST_IGNORED   = 3'd0;
  localparam logic [2:0] ST_PRESET    = 3'd1;
  localparam logic [2:0] ST_TILE      = 3'd2;
  localparam logic [2:0] ST_TILE_XOR  = 3'd3;
  localparam logic [2:0] ST_PALETTE   = 3'd4;
  localparam logic [2:0] ST_UNHANDLED = 3'd5;
  localparam logic [2:0] ST_READ_DONE = 3'd6;

  localparam logic [7:0] MASK_4 = 8'h0F;
  localparam logic [7:0] MASK_5 = 8'h1F;
  localparam logic [7:0] MASK_6 = 8'h3F;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  command;
    logic [5:0]  instruction;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [8:0]  read_x;
    logic [7:0]  read_y;
    logic [3:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  pixel_index;
    logic [23:0] rgb;
    logic        out_of_range;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic        upper;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } pal_load_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_TILE_BASE,
    S_TILE_READ,
    S_TILE_WRITE,
    S_RD_ADDR,
    S_RD_MEM,
    S_RD_DATA,
    S_PAL_REQ,
    S_RD_PAL,
    S_DONE
  } state_t;

  // Byte n of the 16 data bytes, byte 0 in the top of data_low.
  function automatic logic [7:0] pkt_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int n);
    logic [7:0] b;
    if (n < 8) b = lo[(7 - n) * 8 +: 8];
    else       b = hi[(15 - n) * 8 +: 8];
    return b;
  endfunction

  function automatic logic [3:0] pkt_lo4(input logic [63:0] lo, input logic [63:0] hi,
                                         input int n);
    logic [7:0] b;
    b = pkt_byte(lo, hi, n) & MASK_4;
    return b[3:0];
  endfunction

  function automatic logic [4:0] pkt_lo5(input logic [63:0] lo, input logic [63:0] hi,
                                         input int n);
    logic [7:0] b;
    b = pkt_byte(lo, hi, n) & MASK_5;
    return b[4:0];
  endfunction

  function automatic logic [5:0] pkt_lo6(input logic [63:0] lo, input logic [63:0] hi,
                                         input int n);
    logic [7:0] b;
    b = pkt_byte(lo, hi, n) & MASK_6;
    return b[5:0];
  endfunction

endpackage

// ===== hw/rtl/cdgr_palette.sv =====
// 16-entry palette with group load and registered RGB lookup.
module cdgr_palette
  import cdgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pal_load_t   load,
  input  logic [3:0]  rd_idx,
  output logic [23:0] rgb
);

  logic [11:0] pal [16];
  logic [11:0] entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) pal[i] <= '0;
    end else if (load.valid) begin
      // Each entry packs two six-bit data bytes.
      for (int k = 0; k < 8; k++) begin
        pal[{load.upper, 3'(k)}] <= {pkt_lo6(load.data_low, load.data_high, 2 * k),
                                     pkt_lo6(load.data_low, load.data_high, 2 * k + 1)};
      end
    end
  end

  assign entry = pal[rd_idx];

  // Nibble doubling gives c * 17 per channel.
  always_ff @(posedge clk) begin
    rgb <= {entry[11:8], entry[11:8], entry[7:4], entry[7:4], entry[3:0], entry[3:0]};
  end

endmodule

// ===== hw/rtl/cdg_graphics_packet_renderer_core.sv =====
// Top level of the CD+G packet renderer: frame store, sequencer and result register.
// Ignored, unhandled and palette packets go straight to the result register; a palette read
// looks up the palette, a pixel read computes the address, reads the frame store and then the
// palette (off-screen reads skip both), a tile reads then writes each pixel of the frame store,
// and a preset writes one pixel per cycle.
// One item is in work at a time; the next transfer is taken once the previous result
// sits in the output register. After reset the frame store is cleared one entry per
// cycle with in_ready low; the palette clears at once.
module cdg_graphics_packet_renderer_core
  import cdgr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state, state_next;

  logic               accept;
  logic [2:0]         dec_status;
  state_t             dec_state;

  // Frame store
  logic [3:0]         fstore [STORE_SIZE];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [3:0]         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [3:0]         mem_rdata;

  // Fill sweep
  logic [ADDR_W-1:0]  fill_addr;
  logic               fill_boot;
  logic [3:0]         fill_val;

  // Tile walk
  logic               tile_xor;
  logic [3:0]         tile_c0, tile_c1;
  logic [TILE_X_W-1:0] tile_x0, tile_px;
  logic [TILE_Y_W-1:0] tile_y0, tile_py;
  logic [5:0]         tile_bits [TILE_H];
  logic [ROW_W-1:0]   tile_row;
  logic [COL_W-1:0]   tile_col;
  logic [TADDR_W-1:0] tile_addr, tile_row_addr, tile_base;
  logic               tile_on_screen;
  logic               tile_last;
  logic [3:0]         tile_colour;

  // Reads
  logic [8:0]         rd_x;
  logic [7:0]         rd_y;
  logic [3:0]         rd_index;
  logic [RD_W-1:0]    rd_full;
  logic               rd_oor;
  logic [ADDR_W-1:0]  pix_addr;

  logic [3:0]         pal_idx;
  logic [23:0]        pal_rgb;
  pal_load_t          pal_load;

  out_t               res;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign tile_base = TADDR_W'(tile_y0) * TADDR_W'(SCREEN_WIDTH) + TADDR_W'(tile_x0);
  assign tile_on_screen = (tile_px < SCREEN_WIDTH) && (tile_py < SCREEN_HEIGHT);
  assign tile_last = (tile_row == ROW_W'(TILE_H - 1)) && (tile_col == COL_W'(TILE_W - 1));
  assign tile_colour = tile_bits[tile_row][COL_W'(TILE_W - 1) - tile_col] ? tile_c1 : tile_c0;

  assign rd_full = RD_W'(rd_y) * RD_W'(SCREEN_WIDTH) + RD_W'(rd_x);
  assign rd_oor  = (rd_x >= SCREEN_WIDTH) || (rd_y >= SCREEN_HEIGHT);

  assign pal_load.valid = accept && (in_data.kind == KIND_PACKET) &&
                          (in_data.command == CMD_GFX) &&
                          (in_data.instruction inside {INS_PAL_LO, INS_PAL_HI});
  assign pal_load.upper     = (in_data.instruction == INS_PAL_HI);
  assign pal_load.data_low  = in_data.data_low;
  assign pal_load.data_high = in_data.data_high;

  cdgr_palette u_palette (
    .clk    (clk),
    .rst    (rst),
    .load   (pal_load),
    .rd_idx (pal_idx),
    .rgb    (pal_rgb)
  );

  always_ff @(posedge clk) begin
    if (mem_we) fstore[mem_waddr] <= mem_wdata;
    mem_rdata <= fstore[mem_raddr];
  end

  // Decode of an incoming item
  always_comb begin
    dec_status = ST_UNHANDLED;
    dec_state  = S_DONE;
    case (in_data.kind)
      KIND_PACKET: begin
        if (in_data.command != CMD_GFX) begin
          dec_status = ST_IGNORED;
        end else begin
          case (in_data.instruction)
            INS_PRESET: begin
              dec_status = ST_PRESET;
              dec_state  = S_FILL;
            end
            INS_TILE: begin
              dec_status = ST_TILE;
              dec_state  = S_TILE_BASE;
            end
            INS_TILE_XOR: begin
              dec_status = ST_TILE_XOR;
              dec_state  = S_TILE_BASE;
            end
            INS_PAL_LO, INS_PAL_HI: dec_status = ST_PALETTE;
            default: dec_status = ST_UNHANDLED;
          endcase
        end
      end
      KIND_PIXEL: begin
        dec_status = ST_READ_DONE;
        dec_state  = S_RD_ADDR;
      end
      KIND_PAL: begin
        dec_status = ST_READ_DONE;
        dec_state  = S_PAL_REQ;
      end
      default: dec_status = ST_UNHANDLED;
    endcase
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = fill_addr;
    mem_wdata  = fill_val;
    mem_raddr  = tile_addr[ADDR_W-1:0];
    pal_idx    = rd_index;
    case (state)
      S_IDLE: if (accept) state_next = dec_state;
      S_FILL: begin
        mem_we = 1'b1;
        if (fill_addr == ADDR_W'(STORE_SIZE - 1)) state_next = fill_boot ? S_IDLE : S_DONE;
      end
      S_TILE_BASE: state_next = S_TILE_READ;
      S_TILE_READ: state_next = S_TILE_WRITE;
      S_TILE_WRITE: begin
        // Drop pixels past the right or bottom edge.
        mem_we     = tile_on_screen;
        mem_waddr  = tile_addr[ADDR_W-1:0];
        mem_wdata  = tile_xor ? (mem_rdata ^ tile_colour) : tile_colour;
        state_next = tile_last ? S_DONE : S_TILE_READ;
      end
      S_RD_ADDR: state_next = rd_oor ? S_DONE : S_RD_MEM;
      S_RD_MEM: begin
        mem_raddr  = pix_addr;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        pal_idx    = mem_rdata;
        state_next = S_RD_PAL;
      end
      S_PAL_REQ: state_next = S_RD_PAL;
      S_RD_PAL:  state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_addr <= '0;
      fill_boot <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill_addr <= '0;
        fill_boot <= 1'b0;
      end else if (state == S_FILL) begin
        fill_addr <= fill_addr + 1'b1;
      end
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  // Work registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_val <= '0;
    end else if (accept) begin
      fill_val <= pkt_lo4(in_data.data_low, in_data.data_high, 0);
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          res.status       <= dec_status;
          res.pixel_index  <= '0;
          res.rgb          <= '0;
          res.out_of_range <= 1'b0;
          tile_xor <= (in_data.instruction == INS_TILE_XOR);
          tile_c0  <= pkt_lo4(in_data.data_low, in_data.data_high, 0);
          tile_c1  <= pkt_lo4(in_data.data_low, in_data.data_high, 1);
          tile_y0  <= TILE_Y_W'(pkt_lo5(in_data.data_low, in_data.data_high, 2)) *
                      TILE_Y_W'(TILE_H);
          tile_x0  <= TILE_X_W'(pkt_lo6(in_data.data_low, in_data.data_high, 3)) *
                      TILE_X_W'(TILE_W);
          for (int r = 0; r < TILE_H; r++) begin
            tile_bits[r] <= pkt_lo6(in_data.data_low, in_data.data_high, 4 + r);
          end
          rd_x     <= in_data.read_x;
          rd_y     <= in_data.read_y;
          rd_index <= in_data.read_index;
        end
      end
      S_TILE_BASE: begin
        tile_row_addr <= tile_base;
        tile_addr     <= tile_base;
        tile_px       <= tile_x0;
        tile_py       <= tile_y0;
        tile_row      <= '0;
        tile_col      <= '0;
      end
      S_TILE_WRITE: begin
        // Advance along the row, then step down one screen line.
        if (tile_col == COL_W'(TILE_W - 1)) begin
          tile_col      <= '0;
          tile_row      <= tile_row + 1'b1;
          tile_px       <= tile_x0;
          tile_py       <= tile_py + 1'b1;
          tile_row_addr <= tile_row_addr + TADDR_W'(SCREEN_WIDTH);
          tile_addr     <= tile_row_addr + TADDR_W'(SCREEN_WIDTH);
        end else begin
          tile_col  <= tile_col + 1'b1;
          tile_px   <= tile_px + 1'b1;
          tile_addr <= tile_addr + 1'b1;
        end
      end
      S_RD_ADDR: begin
        pix_addr         <= rd_full[ADDR_W-1:0];
        res.out_of_range <= rd_oor;
      end
      S_RD_DATA: res.pixel_index <= mem_rdata;
      S_RD_PAL:  res.rgb         <= pal_rgb;
      S_DONE:    if (out_free) out_data <= res;
      default: ;
    endcase
  end

  // Every transfer in starts work; no write ever leaves the frame store.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item left the sequencer idle");

  a_write_in_store: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr < ADDR_W'(STORE_SIZE)))
    else $error("frame store write beyond the screen");

  a_fill_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (mem_we && !in_ready))
    else $error("fill sweep not writing or taking input");

  a_fill_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && $past(state == S_FILL) && !$past(rst)) |->
      fill_addr == $past(fill_addr) + 1'b1)
    else $error("fill sweep skipped an entry");

  a_tile_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_TILE_WRITE) |-> $past(state == S_TILE_READ))
    else $error("tile write without a preceding read");

endmodule

// ===== tb/sv/cdg_graphics_packet_renderer_core_tb.sv =====
// Self-checking testbench for the CD+G packet renderer: directed rows, then random items.
`timescale 1ns / 1ps

module cdg_graphics_packet_renderer_core_tb
  import cdgr_pkg::*;
();

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 75;
  localparam int CALM_FROM = 60;
  localparam int DRAIN_CYCLES = 160;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic [3:0]  shadow_frame [STORE_SIZE];
  logic [11:0] shadow_palette [16];
  out_t        pending_results [$];
  stim_row_t   directed_rows [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int presets_left = 3;
  int tile_x = 0;
  int tile_y = 0;
  bit calm = 1'b0;
  out_t want;

  cdg_graphics_packet_renderer_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] data_byte(input in_t it, input int n);
    logic [127:0] all;
    all = {it.data_low, it.data_high};
    return all[127 - 8 * n -: 8];
  endfunction

  function automatic logic [23:0] to_rgb24(input logic [11:0] c);
    return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

  function automatic in_t make_item(input logic [1:0] kind, input logic [5:0] cmd,
                                    input logic [5:0] ins, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic [8:0] x,
                                    input logic [7:0] y, input logic [3:0] idx);
    in_t it;
    it.kind = kind;
    it.command = cmd;
    it.instruction = ins;
    it.data_low = lo;
    it.data_high = hi;
    it.read_x = x;
    it.read_y = y;
    it.read_index = idx;
    return it;
  endfunction

  function automatic out_t bare_result(input logic [2:0] st, input logic oor);
    out_t r;
    r = '0;
    r.status = st;
    r.out_of_range = oor;
    return r;
  endfunction

  function automatic void add_row(input in_t item, input bit typed, input out_t result);
    stim_row_t row;
    row.item = item;
    row.typed = typed;
    row.result = result;
    directed_rows.push_back(row);
  endfunction

  // Apply one item to the shadow frame store and palette; return the result it yields.
  function automatic out_t render_item(input in_t it);
    out_t res;
    logic [7:0] b;
    logic [7:0] b2;
    logic [3:0] c0;
    logic [3:0] c1;
    logic [3:0] col;
    logic [3:0] pix;
    logic [5:0] bits;
    int x0;
    int y0;
    int px;
    int py;
    int at;
    int base;
    res = '0;
    res.status = ST_UNHANDLED;
    case (it.kind)
      KIND_PACKET: begin
        if (it.command != CMD_GFX) begin
          res.status = ST_IGNORED;
        end else begin
          case (it.instruction)
            INS_PRESET: begin
              b = data_byte(it, 0);
              for (int i = 0; i < STORE_SIZE; i++) shadow_frame[i] = b[3:0];
              res.status = ST_PRESET;
            end
            INS_TILE, INS_TILE_XOR: begin
              b = data_byte(it, 0);
              c0 = b[3:0];
              b = data_byte(it, 1);
              c1 = b[3:0];
              b = data_byte(it, 2);
              y0 = int'(b[4:0]) * TILE_H;
              b = data_byte(it, 3);
              x0 = int'(b[5:0]) * TILE_W;
              for (int r = 0; r < TILE_H; r++) begin
                b = data_byte(it, 4 + r);
                bits = b[5:0];
                py = y0 + r;
                if (py >= SCREEN_HEIGHT) break;
                for (int c = 0; c < TILE_W; c++) begin
                  px = x0 + c;
                  if (px >= SCREEN_WIDTH) break;
                  // leftmost pixel sits in bit 5
                  col = bits[5 - c] ? c1 : c0;
                  at = py * SCREEN_WIDTH + px;
                  if (it.instruction == INS_TILE_XOR) shadow_frame[at] = shadow_frame[at] ^ col;
                  else shadow_frame[at] = col;
                end
              end
              res.status = (it.instruction == INS_TILE) ? ST_TILE : ST_TILE_XOR;
            end
            INS_PAL_LO, INS_PAL_HI: begin
              base = (it.instruction == INS_PAL_HI) ? 8 : 0;
              for (int k = 0; k < 8; k++) begin
                b = data_byte(it, 2 * k);
                b2 = data_byte(it, 2 * k + 1);
                shadow_palette[base + k] = {b[5:0], b2[5:0]};
              end
              res.status = ST_PALETTE;
            end
            default: ;
          endcase
        end
      end
      KIND_PIXEL: begin
        res.status = ST_READ_DONE;
        if (int'(it.read_x) >= SCREEN_WIDTH || int'(it.read_y) >= SCREEN_HEIGHT) begin
          res.out_of_range = 1'b1;
        end else begin
          pix = shadow_frame[int'(it.read_y) * SCREEN_WIDTH + int'(it.read_x)];
          res.pixel_index = pix;
          res.rgb = to_rgb24(shadow_palette[pix]);
        end
      end
      KIND_PAL: begin
        res.status = ST_READ_DONE;
        res.rgb = to_rgb24(shadow_palette[it.read_index]);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int pick;
    it.kind = KIND_PACKET;
    it.command = 6'($urandom);
    it.instruction = 6'($urandom);
    it.data_low = {$urandom, $urandom};
    it.data_high = {$urandom, $urandom};
    it.read_x = 9'($urandom);
    it.read_y = 8'($urandom);
    it.read_index = 4'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4 && presets_left > 0) begin
      presets_left--;
      it.command = CMD_GFX;
      it.instruction = INS_PRESET;
    end else if (pick < 34) begin
      it.command = CMD_GFX;
      it.instruction = (pick < 22) ? INS_TILE : INS_TILE_XOR;
      // mostly on screen; keep the occasional raw origin for clipping
      if ($urandom_range(0, 7) != 0) begin
        it.data_low[44:40] = 5'($urandom_range(0, 17));
        it.data_low[37:32] = 6'($urandom_range(0, 49));
      end
      tile_x = int'(it.data_low[37:32]) * TILE_W;
      tile_y = int'(it.data_low[44:40]) * TILE_H;
    end else if (pick < 44) begin
      it.command = CMD_GFX;
      it.instruction = $urandom_range(0, 1) ? INS_PAL_HI : INS_PAL_LO;
    end else if (pick < 70) begin
      // read back inside the most recent tile
      it.kind = KIND_PIXEL;
      it.read_x = 9'(tile_x + $urandom_range(0, TILE_W - 1));
      it.read_y = 8'(tile_y + $urandom_range(0, TILE_H - 1));
    end else if (pick < 78) begin
      it.kind = KIND_PIXEL;
    end else if (pick < 88) begin
      it.kind = KIND_PAL;
    end else if (pick < 93) begin
      if (it.command == CMD_GFX) it.command = ~CMD_GFX;
    end else if (pick < 97) begin
      it.command = CMD_GFX;
      case (it.instruction)
        INS_PRESET, INS_TILE, INS_TILE_XOR, INS_PAL_LO, INS_PAL_HI: it.instruction = 6'd20;
        default: ;
      endcase
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

  task automatic drive_item(input in_t item, input bit typed, input out_t typed_res);
    out_t predicted;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predicted = render_item(item);
    pending_results.push_back(typed ? typed_res : predicted);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Result side: random stall bursts, none in the calm tail.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status: expected %0d, got %0d", $time, want.status, out_data.status);
          mismatches++;
        end
        if (out_data.pixel_index !== want.pixel_index) begin
          $display("%0t: pixel_index: expected %0d, got %0d", $time, want.pixel_index,
                   out_data.pixel_index);
          mismatches++;
        end
        if (out_data.rgb !== want.rgb) begin
          $display("%0t: rgb: expected %h, got %h", $time, want.rgb, out_data.rgb);
          mismatches++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range: expected %0d, got %0d", $time, want.out_of_range,
                   out_data.out_of_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: covers the clearing pass after reset and a full preset with margin.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("cdg_graphics_packet_renderer_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_SIZE; i++) shadow_frame[i] = 4'h0;
    for (int i = 0; i < 16; i++) shadow_palette[i] = 12'h000;

    // reads straight after reset see a cleared store and palette
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd0, 8'd0, 4'd0), 1,
            bare_result(ST_READ_DONE, 1'b0));
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd299, 8'd215, 4'd0), 1,
            bare_result(ST_READ_DONE, 1'b0));
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd300, 8'd0, 4'd0), 1,
            bare_result(ST_READ_DONE, 1'b1));
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd0, 8'd216, 4'd0), 1,
            bare_result(ST_READ_DONE, 1'b1));
    add_row(make_item(KIND_PIXEL, '1, '1, '1, '1, 9'd511, 8'd255, 4'd15), 1,
            bare_result(ST_READ_DONE, 1'b1));
    add_row(make_item(KIND_PAL, '0, '0, '0, '0, 9'd0, 8'd0, 4'd15), 1,
            bare_result(ST_READ_DONE, 1'b0));
    // non-graphics commands and unhandled instructions
    add_row(make_item(KIND_PACKET, 6'd0, INS_PRESET, '1, '1, '0, '0, '0), 1,
            bare_result(ST_IGNORED, 1'b0));
    add_row(make_item(KIND_PACKET, 6'd63, INS_TILE, '1, '1, '0, '0, '0), 1,
            bare_result(ST_IGNORED, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, 6'd0, '1, '1, '0, '0, '0), 1,
            bare_result(ST_UNHANDLED, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, 6'd63, '1, '1, '0, '0, '0), 1,
            bare_result(ST_UNHANDLED, 1'b0));
    add_row(make_item(KIND_NONE, CMD_GFX, INS_PRESET, '1, '1, '1, '1, '1), 1,
            bare_result(ST_UNHANDLED, 1'b0));
    // palette loads: all ones low group, mixed values with high bits set in the upper group
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_PAL_LO, '1, '1, '0, '0, '0), 1,
            bare_result(ST_PALETTE, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_PAL_HI, 64'hC102_8304_4506_0708,
                      64'h090A_0B0C_0D0E_0F3F, '0, '0, '0), 1, bare_result(ST_PALETTE, 1'b0));
    add_row(make_item(KIND_PAL, '0, '0, '0, '0, '0, '0, 4'd0), 0, '0);
    add_row(make_item(KIND_PAL, '0, '0, '0, '0, '0, '0, 4'd15), 0, '0);
    // preset to index 15, then read mid-screen
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_PRESET, 64'hFF00_0000_0000_0000, '0,
                      '0, '0, '0), 1, bare_result(ST_PRESET, 1'b0));
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd150, 8'd100, 4'd0), 0, '0);
    // tiles: top-left plain, top-left xor with masked origin bytes,
    // bottom-right corner, and fully off screen
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_TILE, 64'h030A_0000_2A15_3F00,
                      64'h2112_0C33_3F00_2A15, '0, '0, '0), 1, bare_result(ST_TILE, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_TILE_XOR, 64'hFFF5_C0C0_FFFF_FFFF, '1,
                      '0, '0, '0), 1, bare_result(ST_TILE_XOR, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_TILE, 64'h0C05_1131_3F21_0C12,
                      64'h1E2D_3C0F_3300_2A15, '0, '0, '0), 1, bare_result(ST_TILE, 1'b0));
    add_row(make_item(KIND_PACKET, CMD_GFX, INS_TILE, 64'h0708_1F3F_FFFF_FFFF, '1,
                      '0, '0, '0), 1, bare_result(ST_TILE, 1'b0));
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd0, 8'd0, 4'd0), 0, '0);
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd5, 8'd11, 4'd0), 0, '0);
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd294, 8'd204, 4'd0), 0, '0);
    add_row(make_item(KIND_PIXEL, '0, '0, '0, '0, 9'd299, 8'd215, 4'd0), 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    // hold off until everything so far has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FROM);
      drive_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("cdg_graphics_packet_renderer_core_tb: PASS");
    else $display("cdg_graphics_packet_renderer_core_tb: FAIL");
    $finish;
  end

endmodule
